[src/rmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared constants, types and command bundle of the region map decoder.
// ----------------------------------------------------------------------------
package rmd_pkg;

    localparam int TOP_COUNT  = 50;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = 8 * WORD_BYTES;
    localparam int FIELD_W    = 64;
    localparam int BC_W       = 3;
    localparam int RANK_W     = 6;
    localparam int TDATA_W    = 336;

    localparam logic [7:0] SIG_V     = 8'h56;
    localparam logic [7:0] SIG_ONE   = 8'h31;
    localparam logic [7:0] SIG_ZERO  = 8'h00;
    localparam logic [7:0] END_MARK  = 8'hF0;
    localparam int         BASE_BIT  = 6;

    localparam logic [1:0] KIND_REGION = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic ERR_SIGNATURE = 1'b0;
    localparam logic ERR_WORD_SIZE = 1'b1;

    localparam logic [3:0] TYPE_FREE    = 4'd0;
    localparam logic [3:0] TYPE_RESERVE = 4'd1;
    localparam logic [3:0] TYPE_COMMIT  = 4'd2;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic              byte_we;
        logic [BC_W-1:0]   byte_idx;
        logic              type_we;
        logic              seq_base;
        logic              base_done;
        logic              size_done;
        logic              clear_run;
        logic              err_we;
        logic              err_code;
        logic              entry_we;
        logic              entry_last;
        logic [RANK_W-1:0] rank;
    } rmd_cmd_t;

endpackage

[src/rmd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_ctrl
// Header, record and list-dump sequencing of the region map decoder.
// ----------------------------------------------------------------------------
module rmd_ctrl import rmd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [7:0] s_data,
    input  logic       out_free,
    output logic       s_tready,
    output rmd_cmd_t   cmd
);

    typedef enum logic [8:0] {
        ST_SIG0  = 9'b000000001,
        ST_SIG1  = 9'b000000010,
        ST_SIG2  = 9'b000000100,
        ST_WSIZE = 9'b000001000,
        ST_TYPE  = 9'b000010000,
        ST_BASE  = 9'b000100000,
        ST_SIZE  = 9'b001000000,
        ST_HUNT  = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [BC_W-1:0]   cnt_reg, cnt_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              accept, word_end;

    assign s_tready = (state_reg != ST_EMIT) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign word_end = (cnt_reg == BC_W'(WORD_BYTES - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rank_next  = rank_reg;
        cmd        = '0;
        cmd.byte_idx = cnt_reg;
        cmd.rank     = rank_reg;
        unique case (state_reg)
            ST_HUNT: begin
                if (accept && s_data == SIG_V) state_next = ST_SIG1;
            end
            ST_SIG0: begin
                if (accept) begin
                    if (s_data == SIG_V) begin
                        state_next = ST_SIG1;
                    end else begin
                        cmd.err_we   = 1'b1;
                        cmd.err_code = ERR_SIGNATURE;
                        state_next   = ST_HUNT;
                    end
                end
            end
            ST_SIG1: begin
                if (accept) begin
                    if (s_data == SIG_ONE) begin
                        state_next = ST_SIG2;
                    end else begin
                        cmd.err_we   = 1'b1;
                        cmd.err_code = ERR_SIGNATURE;
                        state_next   = ST_HUNT;
                    end
                end
            end
            ST_SIG2: begin
                if (accept) begin
                    if (s_data == SIG_ZERO) begin
                        state_next = ST_WSIZE;
                    end else begin
                        cmd.err_we   = 1'b1;
                        cmd.err_code = ERR_SIGNATURE;
                        state_next   = ST_HUNT;
                    end
                end
            end
            ST_WSIZE: begin
                if (accept) begin
                    if (s_data == 8'(WORD_BYTES)) begin
                        cmd.clear_run = 1'b1;
                        state_next    = ST_TYPE;
                    end else begin
                        cmd.err_we   = 1'b1;
                        cmd.err_code = ERR_WORD_SIZE;
                        state_next   = ST_HUNT;
                    end
                end
            end
            ST_TYPE: begin
                if (accept) begin
                    if (s_data == END_MARK) begin
                        rank_next  = '0;
                        state_next = ST_EMIT;
                    end else begin
                        cmd.type_we  = 1'b1;
                        cmd.seq_base = !s_data[BASE_BIT];
                        cnt_next     = '0;
                        state_next   = s_data[BASE_BIT] ? ST_BASE : ST_SIZE;
                    end
                end
            end
            ST_BASE: begin
                if (accept) begin
                    cmd.byte_we   = 1'b1;
                    cmd.base_done = word_end;
                    cnt_next      = word_end ? '0 : cnt_reg + 1'b1;
                    if (word_end) state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                if (accept) begin
                    cmd.byte_we   = 1'b1;
                    cmd.size_done = word_end;
                    cnt_next      = word_end ? '0 : cnt_reg + 1'b1;
                    if (word_end) state_next = ST_TYPE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.entry_we   = 1'b1;
                    cmd.entry_last = (rank_reg == RANK_W'(TOP_COUNT - 1));
                    rank_next      = rank_reg + 1'b1;
                    if (cmd.entry_last) state_next = ST_HUNT;
                end
            end
            default: state_next = ST_HUNT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SIG0;
            cnt_reg   <= '0;
            rank_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rank_reg  <= rank_next;
        end
    end

endmodule

[src/rmd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_datapath
// Word assembly, running totals, largest-free list and result register.
// ----------------------------------------------------------------------------
module rmd_datapath import rmd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_data,
    input  rmd_cmd_t           cmd,
    input  logic               m_tready,
    output logic               out_free,
    output logic               m_tvalid,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    word_t wbuf_reg, pbase_reg, nbase_reg;
    word_t tfree_reg, tres_reg, tcom_reg;
    word_t tfree_next, tres_next, tcom_next;
    word_t word_now;
    logic [3:0] ptype_reg;
    word_t top_size_reg [TOP_COUNT];
    word_t top_base_reg [TOP_COUNT];
    logic [TOP_COUNT-1:0] ge;
    logic do_insert;

    logic               vld_reg;
    logic [1:0]         kind_reg;
    logic [3:0]         otype_reg;
    logic [FIELD_W-1:0] obase_reg, osize_reg, osf_reg, osr_reg, osc_reg;
    logic [RANK_W-1:0]  orank_reg;
    logic               oerr_reg, olast_reg;

    assign out_free = !vld_reg || m_tready;

    always_comb begin
        word_now = wbuf_reg;
        word_now[8*cmd.byte_idx +: 8] = s_data;
    end

    always_comb begin
        tfree_next = tfree_reg;
        tres_next  = tres_reg;
        tcom_next  = tcom_reg;
        if (ptype_reg == TYPE_FREE)    tfree_next = tfree_reg + word_now;
        if (ptype_reg == TYPE_RESERVE) tres_next  = tres_reg + word_now;
        if (ptype_reg == TYPE_COMMIT)  tcom_next  = tcom_reg + word_now;
    end

    always_comb begin
        for (int i = 0; i < TOP_COUNT; i++) ge[i] = top_size_reg[i] >= word_now;
    end

    assign do_insert = cmd.byte_we && cmd.size_done && (ptype_reg == TYPE_FREE)
                       && !ge[TOP_COUNT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_run) begin
            nbase_reg <= '1;
            tfree_reg <= '0;
            tres_reg  <= '0;
            tcom_reg  <= '0;
            for (int i = 0; i < TOP_COUNT; i++) begin
                top_size_reg[i] <= '0;
                top_base_reg[i] <= '0;
            end
        end else if (cmd.byte_we && cmd.size_done) begin
            tfree_reg <= tfree_next;
            tres_reg  <= tres_next;
            tcom_reg  <= tcom_next;
            nbase_reg <= pbase_reg + word_now;
            if (do_insert) begin
                for (int i = 0; i < TOP_COUNT; i++) begin
                    if (!ge[i]) begin
                        if (i == 0 || ge[(i == 0) ? 0 : i-1]) begin
                            top_size_reg[i] <= word_now;
                            top_base_reg[i] <= pbase_reg;
                        end else begin
                            top_size_reg[i] <= top_size_reg[(i == 0) ? 0 : i-1];
                            top_base_reg[i] <= top_base_reg[(i == 0) ? 0 : i-1];
                        end
                    end
                end
            end
        end else if (cmd.entry_we) begin
            for (int i = 0; i < TOP_COUNT - 1; i++) begin
                top_size_reg[i] <= top_size_reg[i+1];
                top_base_reg[i] <= top_base_reg[i+1];
            end
            top_size_reg[TOP_COUNT-1] <= '0;
            top_base_reg[TOP_COUNT-1] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wbuf_reg  <= '0;
            pbase_reg <= '0;
            ptype_reg <= '0;
        end else if (cmd.type_we) begin
            ptype_reg <= s_data[3:0];
            wbuf_reg  <= '0;
            if (cmd.seq_base) pbase_reg <= nbase_reg;
        end else if (cmd.byte_we) begin
            if (cmd.base_done) begin
                pbase_reg <= word_now;
                wbuf_reg  <= '0;
            end else if (cmd.size_done) begin
                wbuf_reg  <= '0;
            end else begin
                wbuf_reg  <= word_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (cmd.err_we || cmd.entry_we || (cmd.byte_we && cmd.size_done)) begin
            vld_reg <= 1'b1;
        end else if (m_tready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.err_we) begin
            kind_reg  <= KIND_ERROR;
            otype_reg <= '0;
            obase_reg <= '0;
            osize_reg <= '0;
            orank_reg <= '0;
            osf_reg   <= '0;
            osr_reg   <= '0;
            osc_reg   <= '0;
            oerr_reg  <= cmd.err_code;
            olast_reg <= 1'b1;
        end else if (cmd.entry_we) begin
            kind_reg  <= KIND_ENTRY;
            otype_reg <= '0;
            obase_reg <= FIELD_W'(top_base_reg[0]);
            osize_reg <= FIELD_W'(top_size_reg[0]);
            orank_reg <= cmd.rank;
            osf_reg   <= FIELD_W'(tfree_reg);
            osr_reg   <= FIELD_W'(tres_reg);
            osc_reg   <= FIELD_W'(tcom_reg);
            oerr_reg  <= 1'b0;
            olast_reg <= cmd.entry_last;
        end else if (cmd.byte_we && cmd.size_done) begin
            kind_reg  <= KIND_REGION;
            otype_reg <= ptype_reg;
            obase_reg <= FIELD_W'(pbase_reg);
            osize_reg <= FIELD_W'(word_now);
            orank_reg <= '0;
            osf_reg   <= FIELD_W'(tfree_next);
            osr_reg   <= FIELD_W'(tres_next);
            osc_reg   <= FIELD_W'(tcom_next);
            oerr_reg  <= 1'b0;
            olast_reg <= 1'b0;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {5'b0, oerr_reg, osc_reg, osr_reg, osf_reg, orank_reg,
                       osize_reg, obase_reg, otype_reg};

endmodule

[src/region_map_decoder_top_free_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_map_decoder_top_free_core
// Memory-map dump decoder with running totals and a largest-free list.
//
//   channel  | dir | payload
//   s_axis   | in  | tdata[7:0] data_byte
//   m_axis   | out | tuser kind, tlast last, tdata region fields and totals
//
// One input byte per cycle while the result register is empty or being
// taken; any byte stalls while an untaken result is held.
// The end marker starts a dump of TOP_COUNT list entries, one per cycle
// that the receiver takes, during which no input is taken. Reset is
// synchronous, active low, and leaves the block expecting the first
// signature byte.
// ----------------------------------------------------------------------------
module region_map_decoder_top_free_core import rmd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // region_type[3:0], region_base[67:4], region_size[131:68], rank[137:132],
    // sum_free[201:138], sum_reserve[265:202], sum_commit[329:266],
    // error_code[330], zero fill
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast
);

    rmd_cmd_t cmd;
    logic     out_free;

    rmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_data   (s_tdata),
        .out_free (out_free),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    rmd_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_tdata),
        .cmd      (cmd),
        .m_tready (m_tready),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the region map decoder.
//
// Byte-wide dumps go in on the input stream: headers that are good or
// broken, records with and without an explicit base, end markers, and noise.
// A local model of the decoder keeps its own totals and largest-free list and
// queues the expected results for each accepted byte. Every output transfer
// is compared field by field against the oldest queued result. Both sides
// idle at random, and the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_top;
    import rmd_pkg::*;

    typedef enum logic [2:0] {
        PH_SIG0, PH_SIG1, PH_SIG2, PH_WSIZE, PH_TYPE, PH_BASE, PH_SIZE, PH_HUNT
    } phase_t;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  rtype;
        logic [63:0] base;
        logic [63:0] size;
        logic [5:0]  rank;
        logic [63:0] sum_free;
        logic [63:0] sum_rsv;
        logic [63:0] sum_cmt;
        logic        err;
        logic        last;
    } region_out_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    region_out_t expected_q[$];
    int          fail_count = 0;
    bit          idle_on = 1;
    bit          hold_req = 0;

    // decoder model state
    phase_t      mdl_phase;
    int          mdl_count;
    word_t       mdl_buf;
    logic [3:0]  mdl_type;
    word_t       mdl_base;
    word_t       mdl_next;
    word_t       tot_free, tot_rsv, tot_cmt;
    word_t       top_size[TOP_COUNT];
    word_t       top_base[TOP_COUNT];

    region_map_decoder_top_free_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic word_t word_mask();
        return {WORD_W{1'b1}};
    endfunction

    task automatic clear_run();
        tot_free = '0;
        tot_rsv  = '0;
        tot_cmt  = '0;
        for (int i = 0; i < TOP_COUNT; i++) begin
            top_size[i] = '0;
            top_base[i] = '0;
        end
        mdl_next = word_mask();
    endtask

    task automatic push_result(logic [1:0] kind, logic [3:0] rtype, word_t base,
                               word_t size, int rank, bit sums, logic err,
                               logic last);
        region_out_t r;
        r.kind     = kind;
        r.rtype    = rtype;
        r.base     = base;
        r.size     = size;
        r.rank     = rank[5:0];
        r.sum_free = sums ? tot_free : '0;
        r.sum_rsv  = sums ? tot_rsv : '0;
        r.sum_cmt  = sums ? tot_cmt : '0;
        r.err      = err;
        r.last     = last;
        expected_q = {expected_q, r};
    endtask

    task automatic header_fault(logic code);
        push_result(KIND_ERROR, 4'd0, '0, '0, 0, 0, code, 1'b1);
        mdl_phase = PH_HUNT;
    endtask

    task automatic add_free(word_t base, word_t size);
        int pos;
        pos = 0;
        if (!(top_size[TOP_COUNT-1] < size))
            return;
        while (pos < TOP_COUNT - 1 && top_size[pos] >= size)
            pos++;
        for (int j = TOP_COUNT - 1; j > pos; j--) begin
            top_size[j] = top_size[j-1];
            top_base[j] = top_base[j-1];
        end
        top_size[pos] = size;
        top_base[pos] = base;
    endtask

    task automatic decode_byte(logic [7:0] b);
        word_t size;
        case (mdl_phase)
            PH_HUNT: begin
                if (b == SIG_V) mdl_phase = PH_SIG1;
            end
            PH_SIG0: begin
                if (b != SIG_V) header_fault(ERR_SIGNATURE);
                else mdl_phase = PH_SIG1;
            end
            PH_SIG1: begin
                if (b != SIG_ONE) header_fault(ERR_SIGNATURE);
                else mdl_phase = PH_SIG2;
            end
            PH_SIG2: begin
                if (b != SIG_ZERO) header_fault(ERR_SIGNATURE);
                else mdl_phase = PH_WSIZE;
            end
            PH_WSIZE: begin
                if (b != WORD_BYTES[7:0]) header_fault(ERR_WORD_SIZE);
                else begin
                    clear_run();
                    mdl_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (b == END_MARK) begin
                    for (int k = 0; k < TOP_COUNT; k++)
                        push_result(KIND_ENTRY, 4'd0, top_base[k], top_size[k], k, 1,
                                    1'b0, k == TOP_COUNT - 1);
                    mdl_phase = PH_HUNT;
                end else begin
                    mdl_type  = b[3:0];
                    mdl_count = 0;
                    mdl_buf   = '0;
                    if (b[BASE_BIT]) mdl_phase = PH_BASE;
                    else begin
                        mdl_base  = mdl_next;
                        mdl_phase = PH_SIZE;
                    end
                end
            end
            default: begin
                mdl_buf[8*mdl_count +: 8] = b;
                mdl_count++;
                if (mdl_count == WORD_BYTES) begin
                    mdl_count = 0;
                    if (mdl_phase == PH_BASE) begin
                        mdl_base  = mdl_buf;
                        mdl_buf   = '0;
                        mdl_phase = PH_SIZE;
                    end else begin
                        size    = mdl_buf;
                        mdl_buf = '0;
                        if (mdl_type == TYPE_FREE) tot_free = tot_free + size;
                        else if (mdl_type == TYPE_RESERVE) tot_rsv = tot_rsv + size;
                        else if (mdl_type == TYPE_COMMIT) tot_cmt = tot_cmt + size;
                        mdl_next = mdl_base + size;
                        if (mdl_type == TYPE_FREE) add_free(mdl_base, size);
                        push_result(KIND_REGION, mdl_type, mdl_base, size, 0, 1,
                                    1'b0, 1'b0);
                        mdl_phase = PH_TYPE;
                    end
                end
            end
        endcase
    endtask

    // ---- driving ----
    task automatic send_byte(logic [7:0] b);
        if (idle_on && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b);
    endtask

    task automatic send_word(word_t w);
        for (int i = 0; i < WORD_BYTES; i++)
            send_byte(w[8*i +: 8]);
    endtask

    task automatic send_header();
        send_byte(SIG_V);
        send_byte(SIG_ONE);
        send_byte(SIG_ZERO);
        send_byte(WORD_BYTES[7:0]);
    endtask

    task automatic send_region(logic [7:0] tbyte, word_t base, word_t size);
        send_byte(tbyte);
        if (tbyte[BASE_BIT]) send_word(base);
        send_word(size);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return word_t'($urandom_range(0, 255));
            2: return word_t'($urandom);
            default: return word_t'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [7:0] rand_type();
        logic [7:0] t;
        t = 8'($urandom);
        if (t == END_MARK) t = 8'h00;
        if ($urandom_range(0, 1)) t[3:0] = 4'($urandom_range(0, 2));
        return t;
    endfunction

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // ---- tests ----
    task automatic test_header_faults();
        send_byte(8'h57);
        send_byte(8'h31);
        send_byte(SIG_V);
        send_byte(8'h32);
        send_byte(SIG_V);
        send_byte(SIG_ONE);
        send_byte(8'h80);
        send_byte(SIG_V);
        send_byte(SIG_ONE);
        send_byte(SIG_ZERO);
        send_byte(8'h04);
        send_byte(END_MARK);
    endtask

    task automatic test_directed_dump();
        send_header();
        send_region(8'h00, '0, word_mask());
        send_region(8'hB1, word_mask(), 64'h0123_4567_89AB_CDEF);
        send_region(8'h42, 64'h8000_0000_0000_0001, '0);
        send_region(8'h0F, '0, 64'd5);
        send_region(8'h40, 64'h1000, 64'd5);
        send_region(8'h80, '0, 64'd5);
        send_byte(END_MARK);
        send_byte(8'hFF);
        wait_drain();
    endtask

    task automatic test_list_order();
        idle_on = 0;
        send_header();
        for (int i = 0; i < 16; i++)
            send_region(8'h00, '0, word_t'($urandom_range(1, 8)));
        send_byte(END_MARK);
        idle_on = 1;
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        send_header();
        for (int i = 0; i < 3; i++)
            send_region(rand_type(), rand_word(), rand_word());
        send_byte(END_MARK);
        send_header();
        send_region(8'h40, rand_word(), rand_word());
        wait_drain();
    endtask

    task automatic test_random_dumps();
        int n;
        n = 0;
        while (n < 60) begin
            if ($urandom_range(0, 9) == 0) begin
                send_byte(8'($urandom));
                n++;
            end else begin
                send_header();
                n += 4;
                for (int r = $urandom_range(0, 3); r > 0; r--) begin
                    send_region(rand_type(), rand_word(), rand_word());
                    n += 17;
                end
                if ($urandom_range(0, 4) != 0) send_byte(END_MARK);
                else send_byte(SIG_V);
                n++;
            end
        end
    endtask

    // ---- receiver ----
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end else begin
                m_tready <= !idle_on || $urandom_range(0, 99) >= 19;
            end
        end
    end

    // ---- checking ----
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        region_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata[67:4], 64'd0);
            end else begin
                e = expected_q.pop_front();
                if (m_tuser != e.kind)
                    report_mismatch("kind", 64'(m_tuser), 64'(e.kind));
                if (m_tdata[3:0] != e.rtype)
                    report_mismatch("type", 64'(m_tdata[3:0]), 64'(e.rtype));
                if (m_tdata[67:4] != e.base) report_mismatch("base", m_tdata[67:4], e.base);
                if (m_tdata[131:68] != e.size)
                    report_mismatch("size", m_tdata[131:68], e.size);
                if (m_tdata[137:132] != e.rank)
                    report_mismatch("rank", 64'(m_tdata[137:132]), 64'(e.rank));
                if (m_tdata[201:138] != e.sum_free)
                    report_mismatch("sum_free", m_tdata[201:138], e.sum_free);
                if (m_tdata[265:202] != e.sum_rsv)
                    report_mismatch("sum_reserve", m_tdata[265:202], e.sum_rsv);
                if (m_tdata[329:266] != e.sum_cmt)
                    report_mismatch("sum_commit", m_tdata[329:266], e.sum_cmt);
                if (m_tdata[330] != e.err)
                    report_mismatch("error_code", 64'(m_tdata[330]), 64'(e.err));
                if (m_tlast != e.last)
                    report_mismatch("last", 64'(m_tlast), 64'(e.last));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        mdl_phase = PH_SIG0;
        mdl_count = 0;
        mdl_buf   = '0;
        mdl_type  = '0;
        mdl_base  = '0;
        clear_run();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_header_faults();
        test_directed_dump();
        test_list_order();
        test_backpressure();
        test_random_dumps();
        wait_drain();

        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
src/rmd_pkg.sv
src/rmd_ctrl.sv
src/rmd_datapath.sv
src/region_map_decoder_top_free_core.sv
bench/tb_top.sv
